### rtl/core/imuts_pkg.sv
package imuts_pkg;

   localparam int FifoDepth = 16;
   localparam int PtrW = $clog2(FifoDepth);
   localparam int CntW = $clog2(FifoDepth + 1);
   localparam int NumCh = 10;
   localparam int ChW = $clog2(NumCh);
   localparam logic [23:0] GapReset = 24'd200000;

   typedef struct packed {
      logic        func;
      logic [47:0] stamp;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [47:0] out_stamp;
      logic signed [31:0] out_acc_x;
      logic signed [31:0] out_acc_y;
      logic signed [31:0] out_acc_z;
      logic signed [31:0] out_rate_x;
      logic signed [31:0] out_rate_y;
      logic signed [31:0] out_rate_z;
      logic signed [31:0] out_quat_x;
      logic signed [31:0] out_quat_y;
      logic signed [31:0] out_quat_z;
      logic signed [31:0] out_quat_w;
   } rsp_type;

   // sample entry: stamp plus ten channels
   typedef struct packed {
      logic [47:0] stamp;
      logic [NumCh-1:0][31:0] ch;
   } entry_type;

   // shared divider request/response; numerator is {hi, num}, hi must be below den
   typedef struct packed {
      logic        start;
      logic [15:0] hi;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
      logic [63:0] rem;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

### rtl/core/imu_time_sync_interpolator.sv
// IMU time sync interpolator. A push transaction (func=0) stores a timestamped
// sample in a 16-entry FIFO, dropping the oldest when full. A sync transaction
// (func=1) pops stale heads, checks max_gap, then blends the ten channels of the
// two oldest samples with the back weight (sync-front)/(back-front) in Q2.30 and
// renormalizes the quaternion. One 64-bit restoring divider, shared by the weight
// and the normalization, and one sqrt unit serve it: a sync reads both entries,
// divides for the weight, blends each channel, sums the quaternion squares, takes
// the root and divides each quaternion channel by it, then loads the output, with
// most of the time spent in the divider. Failures answer with an all-zero response.
// The result waits in an output register; req_ready stays low while busy.
module imu_time_sync_interpolator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  imuts_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output imuts_pkg::rsp_type   rsp_data,
   input  logic                 csr_we,
   input  logic [23:0]          csr_wdata
);
   import imuts_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_PUSH, S_RD_F, S_RD_B, S_CHECK, S_WDIV, S_WWAIT,
      S_MUL, S_ADD, S_SQ, S_SQACC, S_SQRT, S_SQWAIT, S_NDIV, S_NWAIT,
      S_FAIL, S_OUT
   } state_type;

   state_type state_ff;
   entry_type mem [FifoDepth];
   entry_type rd_ff;
   entry_type front_ff, back_ff;
   req_type   req_ff;
   logic [PtrW-1:0] head_ff, rd_addr;
   logic [CntW-1:0] count_ff;
   logic [23:0] gap_ff;
   logic signed [32:0] wb_ff;
   logic [ChW-1:0] idx_ff;
   logic signed [NumCh-1:0][31:0] res_ff;
   logic signed [65:0] prod_ff;
   logic [63:0] sum_ff;
   logic [31:0] norm_ff;
   logic wneg_ff;
   rsp_type out_ff;
   logic out_valid_ff;
   logic wr_en;
   logic out_load;
   logic [PtrW-1:0] wr_addr;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic sq_start, sq_done;
   logic [31:0] sq_root;

   imuts_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));
   imuts_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start), .value(sum_ff),
                      .done(sq_done), .root(sq_root));

   // arithmetic helpers
   logic [47:0] t;
   logic signed [49:0] num_s, den_s;
   logic [63:0] num_a, den_a;
   logic signed [32:0] diff;
   logic [32:0] ad, aw;
   logic signed [31:0] qc;
   logic [31:0] qa;
   logic signed [63:0] qsq;
   logic [63:0] q_m;
   logic [32:0] w_q;

   assign t = req_ff.stamp;
   assign num_s = $signed({2'b0, t}) - $signed({2'b0, front_ff.stamp});
   assign den_s = $signed({2'b0, back_ff.stamp}) - $signed({2'b0, front_ff.stamp});
   assign num_a = 64'(num_s < 0 ? -num_s : num_s);
   assign den_a = 64'(den_s < 0 ? -den_s : den_s);
   assign diff = $signed({back_ff.ch[idx_ff][31], back_ff.ch[idx_ff]})
               - $signed({front_ff.ch[idx_ff][31], front_ff.ch[idx_ff]});
   assign ad = diff < 0 ? 33'(-diff) : 33'(diff);
   assign aw = wb_ff < 0 ? 33'(-wb_ff) : 33'(wb_ff);
   assign qc = res_ff[idx_ff];
   assign qa = qc[31] ? 32'(-qc) : 32'(qc);
   assign qsq = qc * qc;
   // quotient round: ((a<<30)+n)/(2n)
   assign q_m = div_rsp.quo;
   assign w_q = (div_rsp.quo[63:31] != '0) ? 33'h0_8000_0000 :
                33'({div_rsp.quo[32:0]} + ((div_rsp.rem << 1) >= den_a ? 33'd1 : 33'd0));
   assign wr_addr = PtrW'((count_ff == CntW'(FifoDepth)) ? head_ff + 1'b0 + PtrW'(count_ff)
                                                         : head_ff + PtrW'(count_ff));
   assign out_load = ((state_ff == S_FAIL) || (state_ff == S_OUT)) &&
                     (!out_valid_ff || rsp_ready);

   always_comb begin
      rd_addr = (state_ff == S_RD_B) ? head_ff + PtrW'(1) : head_ff;
      wr_en = (state_ff == S_PUSH);
      div_req = '0;
      sq_start = (state_ff == S_SQRT);
      if (state_ff == S_WDIV) begin
         div_req.start = 1'b1;
         // weight: n*2^30/d, numerator split over hi and num, low bits via remainder
         div_req.hi = num_a[49:34];
         div_req.num = num_a << 30;
         div_req.den = den_a;
      end else if (state_ff == S_NDIV) begin
         div_req.start = 1'b1;
         div_req.num = ({32'b0, qa} << 30) + {32'b0, norm_ff};
         div_req.den = {31'b0, norm_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr].stamp <= req_ff.stamp;
         mem[wr_addr].ch <= {req_ff.quat_w, req_ff.quat_z, req_ff.quat_y, req_ff.quat_x,
                             req_ff.rate_z, req_ff.rate_y, req_ff.rate_x,
                             req_ff.acc_z, req_ff.acc_y, req_ff.acc_x};
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         head_ff <= '0;
         gap_ff <= GapReset;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) gap_ff <= csr_wdata;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  state_ff <= req_data.func ? S_RD_F : S_PUSH;
               end
            end
            S_PUSH: begin
               if (count_ff == CntW'(FifoDepth)) begin
                  head_ff <= head_ff + PtrW'(1);
               end else begin
                  count_ff <= count_ff + CntW'(1);
               end
               state_ff <= S_IDLE;
            end
            S_RD_F: begin
               if (count_ff < CntW'(2)) state_ff <= S_FAIL;
               else state_ff <= S_RD_B;
            end
            S_RD_B: begin
               front_ff <= rd_ff;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               back_ff <= rd_ff;
               if (front_ff.stamp > t) begin
                  state_ff <= S_FAIL;
               end else if (rd_ff.stamp < t) begin
                  head_ff <= head_ff + PtrW'(1);
                  count_ff <= count_ff - CntW'(1);
                  state_ff <= S_RD_F;
               end else if ((t - front_ff.stamp > {24'b0, gap_ff}) ||
                            (rd_ff.stamp - t > {24'b0, gap_ff})) begin
                  head_ff <= head_ff + PtrW'(1);
                  count_ff <= count_ff - CntW'(1);
                  state_ff <= S_RD_F;
                  req_ff.func <= 1'b0; // marks gap-pop done
               end else begin
                  state_ff <= S_WDIV;
               end
               if (!req_ff.func) begin
                  // second pass after gap pop: use entries as they stand, even
                  // when that means extrapolating
                  state_ff <= S_WDIV;
                  head_ff <= head_ff;
                  count_ff <= count_ff;
               end
            end
            S_WDIV: begin
               wneg_ff <= (num_s < 0) != (den_s < 0);
               if (den_s == 0) begin
                  wb_ff <= '0;
                  idx_ff <= '0;
                  state_ff <= S_MUL;
               end else if (num_a >= (den_a << 1)) begin
                  wb_ff <= ((num_s < 0) != (den_s < 0)) ? -33'sh0_8000_0000
                                                        : 33'sh0_8000_0000;
                  idx_ff <= '0;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_WWAIT;
               end
            end
            S_WWAIT: begin
               if (div_rsp.done) begin
                  wb_ff <= wneg_ff ? -$signed(w_q) : $signed(w_q);
                  idx_ff <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff <= $signed({1'b0, 65'((ad * aw + 66'h2000_0000) >> 30)});
               state_ff <= S_ADD;
            end
            S_ADD: begin
               res_ff[idx_ff] <= sat32($signed({{34{front_ff.ch[idx_ff][31]}},
                                                front_ff.ch[idx_ff]}) +
                                       (((diff < 0) != (wb_ff < 0)) ? -prod_ff : prod_ff));
               if (idx_ff == ChW'(NumCh - 1)) begin
                  idx_ff <= ChW'(6);
                  sum_ff <= '0;
                  state_ff <= S_SQ;
               end else begin
                  idx_ff <= idx_ff + ChW'(1);
                  state_ff <= S_MUL;
               end
            end
            S_SQ: begin
               prod_ff <= 66'(qsq);
               state_ff <= S_SQACC;
            end
            S_SQACC: begin
               sum_ff <= sum_ff + (prod_ff[63:0] >> 2);
               if (idx_ff == ChW'(NumCh - 1)) begin
                  state_ff <= S_SQRT;
               end else begin
                  idx_ff <= idx_ff + ChW'(1);
                  state_ff <= S_SQ;
               end
            end
            S_SQRT: state_ff <= S_SQWAIT;
            S_SQWAIT: begin
               if (sq_done) begin
                  norm_ff <= sq_root;
                  idx_ff <= ChW'(6);
                  state_ff <= (sq_root == '0) ? S_OUT : S_NDIV;
               end
            end
            S_NDIV: state_ff <= S_NWAIT;
            S_NWAIT: begin
               if (div_rsp.done) begin
                  res_ff[idx_ff] <= sat32(qc[31] ? -$signed({2'b0, q_m})
                                                 : $signed({2'b0, q_m}));
                  if (idx_ff == ChW'(NumCh - 1)) begin
                     state_ff <= S_OUT;
                  end else begin
                     idx_ff <= idx_ff + ChW'(1);
                     state_ff <= S_NDIV;
                  end
               end
            end
            S_FAIL: begin
               if (out_load) begin
                  out_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  out_ff <= {1'b1, t, res_ff[0], res_ff[1], res_ff[2], res_ff[3],
                             res_ff[4], res_ff[5], res_ff[6], res_ff[7], res_ff[8],
                             res_ff[9]};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
endmodule

### rtl/core/imuts_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit unsigned quotient.
// The partial remainder starts at the high numerator part.
module imuts_div (
   input  logic                   clock,
   input  logic                   reset,
   input  imuts_pkg::div_req_type div_req,
   output imuts_pkg::div_rsp_type div_rsp
);
   import imuts_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[63:0], quo_ff[63]};
      if (div_req.start) begin
         quo_in = div_req.num;
         rem_in = {49'b0, div_req.hi};
         den_in = div_req.den;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff[63:0];
endmodule

### rtl/core/imuts_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
module imuts_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);
   import imuts_pkg::*;

   logic [63:0] rest_ff, rest_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      rest_in = rest_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {1'b0, res_ff} + {1'b0, bit_ff};
      if (start) begin
         rest_in = value;
         res_in = '0;
         bit_in = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rest_ff} >= trial) begin
            rest_in = rest_ff - trial[63:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule
